// ----- rtl/core/baro_temp_pressure_compensation_macros.svh -----
// Assertion macros used by the compensation checker.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BTPC_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BTPC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also checks across reset.
`define BTPC_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons, msg) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/btpc_pkg.sv -----
// Shared types, constants and helpers of the compensation block.
`timescale 1ns / 1ps
package btpc_pkg;

  localparam int DW = 64;

  // Calibration register indexes.
  localparam logic [1:0] REG_TEMP      = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW = 2'd1;
  localparam logic [1:0] REG_PRESS_MID = 2'd2;
  localparam logic [1:0] REG_PRESS_HI  = 2'd3;

  // Offset subtracted from the fine temperature before the pressure terms.
  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [63:0] ADC_SPAN    = 64'd1048576;

  // Sideband carried through the divider and the final stages.
  typedef struct packed {
    logic        neg;
    logic        invalid;
    logic [15:0] temp;
  } div_side_t;

  function automatic logic [63:0] sx16_64(input logic [15:0] x);
    sx16_64 = {{48{x[15]}}, x};
  endfunction

  function automatic logic [31:0] sx16_32(input logic [15:0] x);
    sx16_32 = {{16{x[15]}}, x};
  endfunction

endpackage

// ----- rtl/core/btpc_in_if.sv -----
// Input channel carrying one pair of raw converter readings.
`timescale 1ns / 1ps
interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temp;
  logic [19:0] raw_press;

  modport source (output valid, output raw_temp, output raw_press, input ready);
  modport sink   (input valid, input raw_temp, input raw_press, output ready);
endinterface

// ----- rtl/core/btpc_out_if.sv -----
// Output channel carrying one compensated temperature and pressure result.
`timescale 1ns / 1ps
interface btpc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] temp_centi;
  logic [31:0] press_q24_8;
  logic        press_invalid;

  modport source (output valid, output temp_centi, output press_q24_8,
                  output press_invalid, input ready);
  modport sink   (input valid, input temp_centi, input press_q24_8,
                  input press_invalid, output ready);
endinterface

// ----- rtl/core/baro_temp_pressure_compensation.sv -----
// Top level of the barometric temperature and pressure compensation pipeline.
// Usage:
//   sample : valid/ready channel with raw_temp and raw_press (20 bits each).
//   result : valid/ready channel with temp_centi (signed 0.01 degC),
//            press_q24_8 (Pa x 256) and press_invalid (zero divisor).
//   cfg_we/cfg_index/cfg_data write the four 48-bit calibration registers
//   (0 temp, 1 press low, 2 press mid, 3 press high); write only while idle.
// Throughput: one transaction per cycle while not stalled. Depth: 86 register
//   stages from the input to result valid. The depth is set by the
//   64-stage pipelined divider plus five two-stage 64-bit multipliers in series.
// Reset clears all valid bits and the calibration registers; no result is
//   pending afterwards.
// Stall: the whole pipeline holds while a result waits and result.ready is
//   low; sample.ready drops for those cycles, so nothing is lost or repeated.
//   With result.ready high, sample.ready stays high.
`timescale 1ns / 1ps
module baro_temp_pressure_compensation (
  input  logic              clk,
  input  logic              rst,
  btpc_in_if.sink           sample,
  btpc_out_if.source        result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [47:0]       cfg_data
);

  localparam int         LAT           = 86;

  logic [47:0] temp_coeffs;
  logic [47:0] press_low;
  logic [47:0] press_mid;
  logic [47:0] press_high;

  // Write calibration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      press_low   <= '0;
      press_mid   <= '0;
      press_high  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        btpc_pkg::REG_TEMP:      temp_coeffs <= cfg_data;
        btpc_pkg::REG_PRESS_LOW: press_low   <= cfg_data;
        btpc_pkg::REG_PRESS_MID: press_mid   <= cfg_data;
        btpc_pkg::REG_PRESS_HI:  press_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack coefficients.
  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, temp_coeffs[15:0]};
  assign t2 = btpc_pkg::sx16_32(temp_coeffs[31:16]);
  assign t3 = btpc_pkg::sx16_32(temp_coeffs[47:32]);
  assign p1 = {48'd0, press_low[15:0]};
  assign p2 = btpc_pkg::sx16_64(press_low[31:16]);
  assign p3 = btpc_pkg::sx16_64(press_low[47:32]);
  assign p4 = btpc_pkg::sx16_64(press_mid[15:0]);
  assign p5 = btpc_pkg::sx16_64(press_mid[31:16]);
  assign p6 = btpc_pkg::sx16_64(press_mid[47:32]);
  assign p7 = btpc_pkg::sx16_64(press_high[15:0]);
  assign p8 = btpc_pkg::sx16_64(press_high[31:16]);
  assign p9 = btpc_pkg::sx16_64(press_high[47:32]);

  // Advance the whole pipeline unless the output register is blocked.
  logic [LAT-1:0] vld;
  logic           adv;
  assign adv          = ~vld[LAT-1] | result.ready;
  assign sample.ready = adv;
  assign result.valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], sample.valid};
    end
  end

  // Temperature stages.
  logic [31:0] x1, dd, am, dsq, a3, bm3, fine4;
  logic [19:0] ap1, ap2, ap3, ap4, ap5, ap6, ap7, ap8, ap9, ap10;
  logic [15:0] temp5, temp6, temp7, temp8, temp9, temp10, temp11, temp12, temp13, temp14;
  logic [63:0] v1_5;
  logic [31:0] tt;
  logic [15:0] temp_sat;

  always_comb begin
    tt = 32'($signed(fine4 + {fine4[29:0], 2'b00} + 32'd128) >>> 8);
    if ($signed(tt) < -32'sd32768) begin
      temp_sat = 16'h8000;
    end else if ($signed(tt) > 32'sd32767) begin
      temp_sat = 16'h7fff;
    end else begin
      temp_sat = tt[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1    <= {15'd0, sample.raw_temp[19:3]} - {t1[30:0], 1'b0};
      dd    <= {16'd0, sample.raw_temp[19:4]} - t1;
      ap1   <= sample.raw_press;
      am    <= x1 * t2;
      dsq   <= dd * dd;
      ap2   <= ap1;
      a3    <= 32'($signed(am) >>> 11);
      bm3   <= 32'($signed(dsq) >>> 12) * t3;
      ap3   <= ap2;
      fine4 <= a3 + 32'($signed(bm3) >>> 14);
      ap4   <= ap3;
      temp5 <= temp_sat;
      v1_5  <= {{32{fine4[31]}}, fine4} - btpc_pkg::FINE_OFFSET;
      ap5   <= ap4;
    end
  end

  // First products: square, v1*p5, v1*p2; then square*p6 and square*p3.
  logic [63:0] sq7, v1p5_7, v1p2_7, v1p5_8, v1p2_8, v1p5_9, v1p2_9;
  logic [63:0] sqp6_9, sqp3_9;
  btpc_mul64 u_mul_sq  (.clk, .en(adv), .a(v1_5), .b(v1_5), .p(sq7));
  btpc_mul64 u_mul_p5  (.clk, .en(adv), .a(v1_5), .b(p5),   .p(v1p5_7));
  btpc_mul64 u_mul_p2  (.clk, .en(adv), .a(v1_5), .b(p2),   .p(v1p2_7));
  btpc_mul64 u_mul_p6  (.clk, .en(adv), .a(sq7),  .b(p6),   .p(sqp6_9));
  btpc_mul64 u_mul_p3  (.clk, .en(adv), .a(sq7),  .b(p3),   .p(sqp3_9));

  logic [63:0] v2_10, v1b_10, wv11, num0_11, mf13, mg13, v1f14, num14;
  logic [63:0] ma15, mb15;
  btpc_pkg::div_side_t side15;

  always_ff @(posedge clk) begin
    if (adv) begin
      temp6   <= temp5;
      temp7   <= temp6;
      ap6     <= ap5;
      ap7     <= ap6;
      v1p5_8  <= v1p5_7;
      v1p2_8  <= v1p2_7;
      v1p5_9  <= v1p5_8;
      v1p2_9  <= v1p2_8;
      temp8   <= temp7;
      temp9   <= temp8;
      ap8     <= ap7;
      ap9     <= ap8;
      // Combine the divisor and dividend terms.
      v2_10   <= sqp6_9 + {v1p5_9[46:0], 17'd0} + {p4[28:0], 35'd0};
      v1b_10  <= 64'($signed(sqp3_9) >>> 8) + {v1p2_9[51:0], 12'd0};
      temp10  <= temp9;
      ap10    <= ap9;
      wv11    <= 64'h0000_8000_0000_0000 + v1b_10;
      num0_11 <= ((btpc_pkg::ADC_SPAN - {44'd0, ap10}) << 31) - v2_10;
      temp11  <= temp10;
      temp12  <= temp11;
      temp13  <= temp12;
      v1f14   <= 64'($signed(mf13) >>> 33);
      num14   <= mg13;
      temp14  <= temp13;
      // Take magnitudes and flag a zero divisor.
      ma15         <= num14[63] ? (64'd0 - num14) : num14;
      mb15         <= v1f14[63] ? (64'd0 - v1f14) : v1f14;
      side15.neg     <= num14[63] ^ v1f14[63];
      side15.invalid <= (v1f14 == 64'd0);
      side15.temp    <= temp14;
    end
  end

  btpc_mul64 u_mul_p1 (.clk, .en(adv), .a(wv11),    .b(p1),                    .p(mf13));
  btpc_mul64 u_mul_sc (.clk, .en(adv), .a(num0_11), .b(btpc_pkg::PRESS_SCALE), .p(mg13));

  // Divide.
  logic [63:0]         quo79;
  btpc_pkg::div_side_t side79;
  btpc_div u_div (
    .clk, .en(adv), .num(ma15), .den(mb15), .side_in(side15),
    .quo(quo79), .side_out(side79)
  );

  // Correction terms after the quotient.
  logic [63:0] q80, ps80, q81, ps81, q82, ps82, q83, q84, h82, i82, j84, w2_83, w2_84;
  logic [63:0] sum85, fin;
  btpc_pkg::div_side_t side80, side81, side82, side83, side84, side85;
  logic [63:0] q_fix;

  assign q_fix = side79.neg ? (64'd0 - quo79) : quo79;

  btpc_mul64 u_mul_p9 (.clk, .en(adv), .a(p9),  .b(ps80), .p(h82));
  btpc_mul64 u_mul_p8 (.clk, .en(adv), .a(p8),  .b(q80),  .p(i82));
  btpc_mul64 u_mul_ps (.clk, .en(adv), .a(h82), .b(ps82), .p(j84));

  always_ff @(posedge clk) begin
    if (adv) begin
      q80    <= q_fix;
      ps80   <= 64'($signed(q_fix) >>> 13);
      side80 <= side79;
      q81    <= q80;
      ps81   <= ps80;
      side81 <= side80;
      q82    <= q81;
      ps82   <= ps81;
      side82 <= side81;
      q83    <= q82;
      w2_83  <= 64'($signed(i82) >>> 19);
      side83 <= side82;
      q84    <= q83;
      w2_84  <= w2_83;
      side84 <= side83;
      sum85  <= q84 + 64'($signed(j84) >>> 25) + w2_84;
      side85 <= side84;
    end
  end

  // Scale, offset and saturate the pressure.
  assign fin = 64'($signed(sum85) >>> 8) + {p7[59:0], 4'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      result.temp_centi    <= side85.temp;
      result.press_invalid <= side85.invalid;
      if (side85.invalid || fin[63]) begin
        result.press_q24_8 <= 32'd0;
      end else if (|fin[62:32]) begin
        result.press_q24_8 <= 32'hffff_ffff;
      end else begin
        result.press_q24_8 <= fin[31:0];
      end
    end
  end

endmodule

// ----- rtl/core/btpc_mul64.sv -----
// Two-stage multiplier giving the low 64 bits of a 64 by 64 product.
`timescale 1ns / 1ps
module btpc_mul64 (
  input  logic                    clk,
  input  logic                    en,
  input  logic [btpc_pkg::DW-1:0] a,
  input  logic [btpc_pkg::DW-1:0] b,
  output logic [btpc_pkg::DW-1:0] p
);

  localparam int HW = btpc_pkg::DW / 2;

  logic [btpc_pkg::DW-1:0] pp_low;
  logic [HW-1:0]           pp_ab;
  logic [HW-1:0]           pp_ba;

  // Form the partial products; the high-by-high term falls off the top.
  always_ff @(posedge clk) begin
    if (en) begin
      pp_low <= {{HW{1'b0}}, a[HW-1:0]} * {{HW{1'b0}}, b[HW-1:0]};
      pp_ab  <= a[HW-1:0] * b[btpc_pkg::DW-1:HW];
      pp_ba  <= a[btpc_pkg::DW-1:HW] * b[HW-1:0];
    end
  end

  // Add the cross terms into the upper half.
  always_ff @(posedge clk) begin
    if (en) begin
      p <= pp_low + {pp_ab + pp_ba, {HW{1'b0}}};
    end
  end

endmodule

// ----- rtl/core/btpc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, unsigned 64 by 64.
`timescale 1ns / 1ps
module btpc_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [btpc_pkg::DW-1:0] num,
  input  logic [btpc_pkg::DW-1:0] den,
  input  btpc_pkg::div_side_t     side_in,
  output logic [btpc_pkg::DW-1:0] quo,
  output btpc_pkg::div_side_t     side_out
);

  localparam int W = btpc_pkg::DW;

  logic [W-1:0]        rem  [0:W];
  logic [W-1:0]        dq   [0:W];
  logic [W-1:0]        dv   [0:W];
  btpc_pkg::div_side_t sd   [0:W];

  assign rem[0] = '0;
  assign dq[0]  = num;
  assign dv[0]  = den;
  assign sd[0]  = side_in;

  genvar k;
  generate
    for (k = 0; k < W; k++) begin : g_stage
      logic [W:0] trial;
      logic [W:0] diff;
      logic       ge;

      // Shift in the next dividend bit and try the subtract.
      always_comb begin
        trial = {rem[k], dq[k][W-1]};
        diff  = trial - {1'b0, dv[k]};
        ge    = ~diff[W];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? diff[W-1:0] : trial[W-1:0];
          dq[k+1]  <= {dq[k][W-2:0], ge};
          dv[k+1]  <= dv[k];
          sd[k+1]  <= sd[k];
        end
      end
    end
  endgenerate

  assign quo      = dq[W];
  assign side_out = sd[W];

endmodule

// ----- rtl/core/btpc_checker.sv -----
// Port-level checker for the compensation block, bound to its top level.
`timescale 1ns / 1ps
`include "baro_temp_pressure_compensation_macros.svh"
module btpc_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [15:0] temp_centi,
  input logic [31:0] press_q24_8,
  input logic        press_invalid
);

  // Hold a stalled result.
  `BTPC_ASSERT_NEXT(a_out_hold, clk, rst, result_valid && !result_ready, result_valid, "result dropped while stalled")
  `BTPC_ASSERT_NEXT(a_out_stable, clk, rst, result_valid && !result_ready, $stable(press_q24_8) && $stable(temp_centi), "stalled result changed")
  // Zero divisor forces zero pressure.
  `BTPC_ASSERT_IMP(a_invalid_zero, clk, rst, result_valid && press_invalid, press_q24_8 == 32'd0, "invalid pressure not zero")
  // An empty output register never blocks the input.
  `BTPC_ASSERT_IMP(a_ready_free, clk, rst, !result_valid, sample_ready, "input blocked with output empty")
  // Reset empties the pipeline.
  `BTPC_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !result_valid, "result valid after reset")

endmodule

bind baro_temp_pressure_compensation btpc_checker u_btpc_checker (
  .clk           (clk),
  .rst           (rst),
  .sample_ready  (sample.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .temp_centi    (result.temp_centi),
  .press_q24_8   (result.press_q24_8),
  .press_invalid (result.press_invalid)
);

// ----- test/tb.sv -----
// Testbench for the barometric compensation pipeline: random stimulus, predictor, scoreboard.
`timescale 1ns / 1ps
module tb;

  localparam int LATENCY   = 86;
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 1800;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } reading_t;

  typedef struct packed {
    logic [15:0] temp_centi;
    logic [31:0] press_q24_8;
    logic        press_invalid;
  } comp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = btpc_pkg::REG_TEMP;
  logic [47:0] cfg_data = '0;

  btpc_in_if  sample ();
  btpc_out_if result ();

  baro_temp_pressure_compensation dut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [47:0] calib [4];
  reading_t    pending_readings[$];
  comp_t       expected_comp[$];
  int          failures = 0;
  int          cycles = 0;
  bit          driving_done = 1'b0;
  bit          in_taken = 1'b0;

  // Compute the compensated pair from raw readings and the current calibration.
  function automatic comp_t compensate(reading_t r);
    logic signed [31:0] t1, t2, t3, a, d, b, fine, t;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] v1, v2, p, ps, w1, w2;
    logic [47:0] ct, cl, cm, ch;
    comp_t c;
    ct = calib[btpc_pkg::REG_TEMP];
    cl = calib[btpc_pkg::REG_PRESS_LOW];
    cm = calib[btpc_pkg::REG_PRESS_MID];
    ch = calib[btpc_pkg::REG_PRESS_HI];
    t1 = {16'd0, ct[15:0]};
    t2 = {{16{ct[31]}}, ct[31:16]};
    t3 = {{16{ct[47]}}, ct[47:32]};
    a = ((($signed({15'd0, r.raw_temp[19:3]})) - (t1 <<< 1)) * t2) >>> 11;
    d = $signed({16'd0, r.raw_temp[19:4]}) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    fine = a + b;
    t = (fine * 32'sd5 + 32'sd128) >>> 8;
    if (t < -32768) c.temp_centi = 16'h8000;
    else if (t > 32767) c.temp_centi = 16'h7fff;
    else c.temp_centi = t[15:0];
    p1 = {48'd0, cl[15:0]};
    p2 = {{48{cl[31]}}, cl[31:16]};
    p3 = {{48{cl[47]}}, cl[47:32]};
    p4 = {{48{cm[15]}}, cm[15:0]};
    p5 = {{48{cm[31]}}, cm[31:16]};
    p6 = {{48{cm[47]}}, cm[47:32]};
    p7 = {{48{ch[15]}}, ch[15:0]};
    p8 = {{48{ch[31]}}, ch[31:16]};
    p9 = {{48{ch[47]}}, ch[47:32]};
    v1 = 64'(fine) - 64'sd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) <<< 17);
    v2 = v2 + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
    if (v1 == 0) begin
      c.press_q24_8 = '0;
      c.press_invalid = 1'b1;
    end else begin
      p = 64'sd1048576 - $signed({44'd0, r.raw_press});
      p = ((p <<< 31) - v2) * 64'sd3125;
      // Most negative over -1 wraps to itself.
      if (p == {1'b1, 63'd0} && v1 == -64'sd1) p = p;
      else p = p / v1;
      ps = p >>> 13;
      w1 = (p9 * ps * ps) >>> 25;
      w2 = (p8 * p) >>> 19;
      p = ((p + w1 + w2) >>> 8) + (p7 <<< 4);
      if (p < 0) c.press_q24_8 = '0;
      else if (p > 64'sd4294967295) c.press_q24_8 = 32'hffff_ffff;
      else c.press_q24_8 = p[31:0];
      c.press_invalid = 1'b0;
    end
    return c;
  endfunction

  // Drive sample transactions from the pending queue with random gaps.
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_taken = 1'b0;
        void'(pending_readings.pop_front());
        send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
      end
      if (send_gap > 0) begin
        send_gap--;
        sample.valid <= 1'b0;
      end else if (pending_readings.size() > 0) begin
        sample.valid <= 1'b1;
        sample.raw_temp <= pending_readings[0].raw_temp;
        sample.raw_press <= pending_readings[0].raw_press;
      end else begin
        sample.valid <= 1'b0;
      end
    end
  end

  // Predict on accept, check on result, and randomize the result stall.
  int recv_gap = 0;
  always @(posedge clk) begin
    reading_t r;
    comp_t got, want;
    cycles++;
    if (!rst) begin
      if (sample.valid && sample.ready) begin
        in_taken = 1'b1;
        r.raw_temp = sample.raw_temp;
        r.raw_press = sample.raw_press;
        expected_comp.push_back(compensate(r));
      end
      if (result.valid && result.ready) begin
        got = {result.temp_centi, result.press_q24_8, result.press_invalid};
        if (expected_comp.size() == 0) begin
          $error("unexpected result transaction");
          failures++;
        end else begin
          want = expected_comp.pop_front();
          if (got.temp_centi !== want.temp_centi) begin
            $error("temp_centi: expected %0d, got %0d",
                   $signed(want.temp_centi), $signed(got.temp_centi));
            failures++;
          end
          if (got.press_q24_8 !== want.press_q24_8) begin
            $error("press_q24_8: expected %0d, got %0d", want.press_q24_8, got.press_q24_8);
            failures++;
          end
          if (got.press_invalid !== want.press_invalid) begin
            $error("press_invalid: expected %0b, got %0b",
                   want.press_invalid, got.press_invalid);
            failures++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (recv_gap > 0) begin
        recv_gap--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) recv_gap = $urandom_range(0, 15);
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    if (cycles > MAX_CYC) begin
      $display("** baro_temp_pressure_compensation: FAILED **");
      $finish;
    end
  end

  task automatic write_calib(input logic [1:0] idx, input logic [47:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    calib[idx] = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_readings.size() == 0 && expected_comp.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic reading_t rand_reading();
    reading_t r;
    r.raw_temp = $urandom_range(0, 1048575);
    r.raw_press = $urandom_range(0, 1048575);
    if ($urandom_range(0, 9) < 7) begin
      // Realistic readings near room temperature and sea level.
      r.raw_temp = $urandom_range(480000, 560000);
      r.raw_press = $urandom_range(250000, 450000);
    end
    return r;
  endfunction

  // Load a typical factory calibration set.
  task automatic load_typical();
    write_calib(btpc_pkg::REG_TEMP, {16'hfc18, 16'h6810, 16'd27504});
    write_calib(btpc_pkg::REG_PRESS_LOW, {16'h2030, 16'hd3c6, 16'd36477});
    write_calib(btpc_pkg::REG_PRESS_MID, {16'hfff9, 16'h008c, 16'h0b31});
    write_calib(btpc_pkg::REG_PRESS_HI, {16'h1770, 16'hd804, 16'h3c3e});
  endtask

  initial begin
    reading_t r;
    sample.valid = 1'b0;
    sample.raw_temp = '0;
    sample.raw_press = '0;
    result.ready = 1'b0;
    for (int i = 0; i < 4; i++) calib[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // All-zero calibration: divisor zero, invalid flag.
    pending_readings.push_back('{20'd0, 20'd0});
    pending_readings.push_back('{20'hfffff, 20'hfffff});
    drain();

    // Typical set with field extremes.
    load_typical();
    pending_readings.push_back('{20'd0, 20'd0});
    pending_readings.push_back('{20'hfffff, 20'hfffff});
    pending_readings.push_back('{20'd519888, 20'd415148});
    pending_readings.push_back('{20'd0, 20'hfffff});
    pending_readings.push_back('{20'hfffff, 20'd0});
    drain();

    // Extreme coefficients drive saturation both ways.
    write_calib(btpc_pkg::REG_TEMP, 48'hffff_ffff_ffff);
    write_calib(btpc_pkg::REG_PRESS_LOW, {16'h7fff, 16'h8000, 16'hffff});
    write_calib(btpc_pkg::REG_PRESS_MID, {16'h8000, 16'h7fff, 16'h8000});
    write_calib(btpc_pkg::REG_PRESS_HI, {16'h7fff, 16'h8000, 16'h7fff});
    pending_readings.push_back('{20'd0, 20'd0});
    pending_readings.push_back('{20'hfffff, 20'hfffff});
    pending_readings.push_back('{20'h80000, 20'h55555});
    drain();
    write_calib(btpc_pkg::REG_TEMP, {16'h7fff, 16'h7fff, 16'h0000});
    write_calib(btpc_pkg::REG_PRESS_HI, {16'h8000, 16'h7fff, 16'h8000});
    pending_readings.push_back('{20'd0, 20'hfffff});
    pending_readings.push_back('{20'hfffff, 20'd0});
    drain();

    // Random phases with random or typical calibration.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) load_typical();
      else begin
        write_calib(btpc_pkg::REG_TEMP, 48'({$urandom, $urandom}));
        write_calib(btpc_pkg::REG_PRESS_LOW, 48'({$urandom, $urandom}));
        write_calib(btpc_pkg::REG_PRESS_MID, 48'({$urandom, $urandom}));
        write_calib(btpc_pkg::REG_PRESS_HI, 48'({$urandom, $urandom}));
      end
      for (int i = 0; i < N_RANDOM / 6; i++) begin
        r = rand_reading();
        pending_readings.push_back(r);
      end
      drain();
    end

    if (failures == 0) $display("** baro_temp_pressure_compensation: PASSED **");
    else $display("** baro_temp_pressure_compensation: FAILED **");
    $finish;
  end

endmodule
